[hdl/sros_pkg.sv]
// shared types and constants for the random output scheduler
// no dependencies
`default_nettype none
package sros_pkg;
    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_ARRIVE  = 2'd1,
        CMD_SERVE   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    localparam int SLOT_W = 32;
    localparam int PORT_W = 4;
    localparam int RND_W  = 16;
    localparam int LIM_W  = 4;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd4;

    // one queue entry: source port and arrival slot
    typedef struct packed {
        logic [PORT_W-1:0] src;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    // control broadcast from the queue controller to every cell
    typedef struct packed {
        logic              write;   // load entry at position wr_pos
        logic              shift;   // cells at or above pick_pos take their upper neighbor
        logic [7:0]        wr_pos;
        logic [7:0]        pick_pos;
    } cell_ctl_t;
endpackage
`default_nettype wire

[hdl/sros_cell.sv]
// one storage cell of an output queue; holds one entry
// depends on sros_pkg
`default_nettype none
module sros_cell #(
    parameter logic [7:0] POS = 8'd0
) (
    input  wire                  clk,
    input  wire sros_pkg::cell_ctl_t ctl,
    input  wire sros_pkg::entry_t    wr_entry,
    input  wire sros_pkg::entry_t    upper,
    output sros_pkg::entry_t         entry
);
    sros_pkg::entry_t entry_reg;

    // load on append, take neighbor on close-up
    always_ff @(posedge clk)
    begin
        if (ctl.write && ctl.wr_pos == POS)
        begin
            entry_reg <= wr_entry;
        end
        else if (ctl.shift && POS >= ctl.pick_pos)
        begin
            entry_reg <= upper;
        end
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire

[hdl/sros_queue.sv]
// one output queue built as a row of cells
// depends on sros_pkg, sros_cell
`default_nettype none
module sros_queue #(
    parameter int CAP = 32
) (
    input  wire                  clk,
    input  wire sros_pkg::cell_ctl_t ctl,
    input  wire sros_pkg::entry_t    wr_entry,
    input  wire [7:0]            rd_pos,
    output sros_pkg::entry_t         rd_entry
);
    sros_pkg::entry_t cells [CAP+1];

    // top neighbor of the last cell is a don't-care
    assign cells[CAP] = wr_entry;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        sros_cell #(.POS(8'(i))) u_cell (
            .clk(clk), .ctl(ctl), .wr_entry(wr_entry),
            .upper(cells[i+1]), .entry(cells[i])
        );
    end

    // picked entry read
    always_comb
    begin
        rd_entry = cells[0];
        for (int i = 0; i < CAP; i++)
        begin
            if (rd_pos == 8'(i))
            begin
                rd_entry = cells[i];
            end
        end
    end
endmodule
`default_nettype wire

[hdl/switch_random_output_scheduler.sv]
// top level of the random output scheduler
// depends on sros_pkg, sros_queue, sros_cell
`default_nettype none
// Takes one command at a time. An advance, an arrival, an unused command or a
// serve that sends nothing presents its result in the cycle after its transfer.
// A serve of a nonempty queue first runs bit-serial restoring division in
// ST_DIV that forms random_value mod queue length, then passes through ST_PICK,
// in which the picked entry is read and removed, the picked cell and every cell
// above it taking its upper neighbor, and then presents its result. A result
// sits in an output register until taken, and the input opens again in the
// cycle after that. No clearing pass after reset.
module switch_random_output_scheduler #(
    parameter int PORTS        = 4,
    parameter int BUFFER_DEPTH = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [3:0]   cfg_data,
    input  wire         s_tvalid,
    output logic        s_tready,
    // command[1:0], source_port[5:2], dest_port[9:6], random_value[25:10]
    input  wire [31:0]  s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // accepted[0], served[1], served_source[5:2], packet_delay[37:6]
    output logic [39:0] m_tdata
);
    localparam int CAP   = PORTS * BUFFER_DEPTH;
    localparam int LEN_W = $clog2(CAP + 1);
    localparam int PI_W  = (PORTS > 1) ? $clog2(PORTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PICK, ST_OUT} state_t;

    state_t state_reg;
    logic [3:0] limit_reg;
    logic [31:0] slot_reg;
    logic [LEN_W-1:0] qlen_reg [PORTS];
    logic [LEN_W-1:0] occ_reg [PORTS];
    logic [PI_W-1:0] dst_reg;
    logic [15:0] quo_reg;
    logic [LEN_W:0] rem_reg;
    logic [4:0] cnt_reg;
    logic res_acc_reg, res_srv_reg;
    logic [3:0] res_src_reg;
    logic [31:0] res_dly_reg;

    wire [1:0]  cmd = s_tdata[1:0];
    wire [3:0]  src = s_tdata[5:2];
    wire [3:0]  dst = s_tdata[9:6];
    wire [15:0] rnd = s_tdata[25:10];
    wire xfer = s_tvalid && s_tready;

    wire [3:0] lim = (32'(limit_reg) > 32'(BUFFER_DEPTH)) ? 4'(BUFFER_DEPTH) : limit_reg;
    wire src_ok = 32'(src) < 32'(PORTS);
    wire dst_ok = 32'(dst) < 32'(PORTS);
    wire [PI_W-1:0] src_i = src[PI_W-1:0];
    wire [PI_W-1:0] dst_i = dst[PI_W-1:0];
    wire arrive_ok = src_ok && dst_ok && (32'(occ_reg[src_i]) < 32'(lim))
                     && (32'(qlen_reg[dst_i]) < 32'(CAP));
    wire serve_go = (cmd == sros_pkg::CMD_SERVE) && dst_ok && (qlen_reg[dst_i] != '0);

    sros_pkg::cell_ctl_t ctl [PORTS];
    sros_pkg::entry_t rd [PORTS];
    sros_pkg::entry_t wr_e;
    assign wr_e.src  = src;
    assign wr_e.slot = slot_reg;

    // restoring division step
    wire [LEN_W:0] rem_sh = {rem_reg[LEN_W-1:0], quo_reg[15]};
    wire [LEN_W:0] len_x = {1'b0, qlen_reg[dst_reg]};
    wire rem_ge = rem_sh >= len_x;

    for (genvar p = 0; p < PORTS; p++)
    begin : g_q
        always_comb
        begin
            ctl[p].write    = xfer && cmd == sros_pkg::CMD_ARRIVE && arrive_ok
                              && dst_i == PI_W'(p);
            ctl[p].wr_pos   = 8'(qlen_reg[p]);
            ctl[p].shift    = state_reg == ST_PICK && dst_reg == PI_W'(p);
            ctl[p].pick_pos = 8'(rem_reg);
        end
        sros_queue #(.CAP(CAP)) u_q (
            .clk(clk), .ctl(ctl[p]), .wr_entry(wr_e),
            .rd_pos(8'(rem_reg)), .rd_entry(rd[p])
        );
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {2'b00, res_dly_reg, res_src_reg, res_srv_reg, res_acc_reg};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= sros_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= 32'd1;
            for (int p = 0; p < PORTS; p++)
            begin
                qlen_reg[p] <= '0;
                occ_reg[p]  <= '0;
            end
            dst_reg <= '0; quo_reg <= '0; rem_reg <= '0; cnt_reg <= '0;
            res_acc_reg <= 1'b0; res_srv_reg <= 1'b0;
            res_src_reg <= '0; res_dly_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (xfer)
                    begin
                        res_acc_reg <= (cmd == sros_pkg::CMD_ARRIVE) && arrive_ok;
                        res_srv_reg <= 1'b0;
                        res_src_reg <= '0;
                        res_dly_reg <= '0;
                        state_reg   <= serve_go ? ST_DIV : ST_OUT;
                        unique case (cmd)
                            sros_pkg::CMD_ADVANCE: slot_reg <= slot_reg + 32'd1;
                            sros_pkg::CMD_ARRIVE:
                            begin
                                if (arrive_ok)
                                begin
                                    qlen_reg[dst_i] <= qlen_reg[dst_i] + LEN_W'(1);
                                    occ_reg[src_i] <= occ_reg[src_i] + LEN_W'(1);
                                end
                            end
                            sros_pkg::CMD_SERVE:
                            begin
                                if (serve_go)
                                begin
                                    dst_reg <= dst_i; quo_reg <= rnd;
                                    rem_reg <= '0; cnt_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_ge ? rem_sh - len_x : rem_sh;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    qlen_reg[dst_reg] <= qlen_reg[dst_reg] - LEN_W'(1);
                    if (32'(rd[dst_reg].src) < 32'(PORTS)
                        && occ_reg[rd[dst_reg].src[PI_W-1:0]] != '0)
                    begin
                        occ_reg[rd[dst_reg].src[PI_W-1:0]] <=
                            occ_reg[rd[dst_reg].src[PI_W-1:0]] - LEN_W'(1);
                    end
                    res_srv_reg <= 1'b1;
                    res_src_reg <= rd[dst_reg].src;
                    res_dly_reg <= slot_reg + 32'd1 - rd[dst_reg].slot;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK |-> 32'(rem_reg) < 32'(qlen_reg[dst_reg]))
        else $error("pick index beyond queue length");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_serve_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(res_acc_reg && res_srv_reg)) else $error("both flags set");
endmodule
`default_nettype wire

[dv/switch_random_output_scheduler_chk.sv]
// checker for the random output scheduler: watches both streams and the
// config port, predicts every result and compares; depends on sros_pkg
`timescale 1ns / 100ps
`default_nettype none
module switch_random_output_scheduler_chk #(
    parameter int PORTS        = 4,
    parameter int BUFFER_DEPTH = 8
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire [3:0]   cfg_data,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [31:0]  s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [39:0]  m_tdata,
    output int          fail_count,
    output int          pending
);
    localparam int QCAP = PORTS * BUFFER_DEPTH;

    typedef struct packed {
        logic [31:0] delay;
        logic [3:0]  src;
        logic        served;
        logic        accepted;
    } sched_result_t;

    // scheduler state as the predictor sees it
    logic [3:0]   lim_reg;
    logic [31:0]  slot_now;
    int           occ [PORTS];
    sros_pkg::entry_t outq [PORTS][$];
    sched_result_t expected_results [$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic sched_result_t schedule_step(input logic [31:0] d);
        sched_result_t r;
        sros_pkg::cmd_t c;
        int     sp, dp, lim, len, pick;
        sros_pkg::entry_t e;
        r   = '0;
        c   = sros_pkg::cmd_t'(d[1:0]);
        sp  = int'(d[5:2]);
        dp  = int'(d[9:6]);
        lim = (int'(lim_reg) > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(lim_reg);
        unique case (c)
            sros_pkg::CMD_ADVANCE: slot_now = slot_now + 32'd1;
            sros_pkg::CMD_ARRIVE:
                if (sp < PORTS && dp < PORTS && occ[sp] < lim && outq[dp].size() < QCAP)
                begin
                    e.src  = sp[3:0];
                    e.slot = slot_now;
                    outq[dp] = {outq[dp], e};
                    occ[sp]++;
                    r.accepted = 1'b1;
                end
            sros_pkg::CMD_SERVE:
                if (dp < PORTS && outq[dp].size() > 0)
                begin
                    len  = outq[dp].size();
                    pick = int'(d[25:10]) % len;
                    e    = outq[dp][pick];
                    outq[dp].delete(pick);
                    if (occ[e.src] > 0)
                        occ[e.src]--;
                    r.served = 1'b1;
                    r.src    = e.src;
                    r.delay  = slot_now + 32'd1 - e.slot;
                end
            default: ;
        endcase
        return r;
    endfunction

    // track config, predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want, got;
        if (!rst_n)
        begin
            lim_reg  <= sros_pkg::LIMIT_RESET;
            slot_now = 32'd1;
            for (int p = 0; p < PORTS; p++)
            begin
                occ[p] = 0;
                outq[p].delete();
            end
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
                lim_reg <= cfg_data;
            if (s_tvalid && s_tready)
                expected_results = {expected_results, schedule_step(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[37:0];
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_tdata, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.served !== want.served)
                        report_mismatch("served", got.served, want.served);
                    if (got.src !== want.src)
                        report_mismatch("served_source", got.src, want.src);
                    if (got.delay !== want.delay)
                        report_mismatch("packet_delay", got.delay, want.delay);
                end
            end
        end
    end
endmodule
`default_nettype wire

[dv/switch_random_output_scheduler_tb.sv]
// testbench top for the random output scheduler: clock, reset, stimulus, verdict
// depends on sros_pkg, the scheduler RTL and switch_random_output_scheduler_chk
`timescale 1ns / 100ps
`default_nettype none
module switch_random_output_scheduler_tb;
    localparam int PORTS      = 4;
    localparam int RAND_ITEMS = 1850;
    localparam int STALL_MAX  = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    wire         s_tready;
    logic [31:0] s_tdata;
    wire         m_tvalid;
    logic        m_tready;
    wire  [39:0] m_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          calm;

    switch_random_output_scheduler #(.PORTS(PORTS), .BUFFER_DEPTH(8)) u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    switch_random_output_scheduler_chk #(.PORTS(PORTS), .BUFFER_DEPTH(8)) u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver side: random stall bursts, none in the calm part
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // one command transfer, with an optional gap in front
    task automatic send_cmd(input sros_pkg::cmd_t c, input int sp, input int dp,
                            input int rnd);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, rnd[15:0], dp[3:0], sp[3:0], c};
        // ready only changes at a rising edge, so look at it between edges
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_and_set_limit(input logic [3:0] lim);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_cmd();
        int r, sp, dp;
        r  = $urandom_range(0, 99);
        sp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(0, PORTS - 1);
        dp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(0, PORTS - 1);
        if (r < 15)
            send_cmd(sros_pkg::CMD_ADVANCE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        else if (r < 55)
            send_cmd(sros_pkg::CMD_ARRIVE, sp, dp, $urandom_range(0, 65535));
        else if (r < 97)
            send_cmd(sros_pkg::CMD_SERVE, $urandom_range(0, 15), dp, $urandom_range(0, 65535));
        else
            send_cmd(sros_pkg::CMD_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
    endtask

    // stimulus and verdict
    initial
    begin
        logic [3:0] limits [5];
        limits      = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 4'd0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit, fill, refuse, serve, bad ports, unused command
        send_cmd(sros_pkg::CMD_SERVE, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            send_cmd(sros_pkg::CMD_ARRIVE, 0, i % 2, 16'hffff);
        send_cmd(sros_pkg::CMD_ADVANCE, 15, 15, 16'hffff);
        send_cmd(sros_pkg::CMD_ARRIVE, 15, 0, 0);
        send_cmd(sros_pkg::CMD_ARRIVE, 1, 15, 0);
        send_cmd(sros_pkg::CMD_ARRIVE, 3, 3, 0);
        send_cmd(sros_pkg::CMD_SERVE, 0, 15, 0);
        send_cmd(sros_pkg::CMD_NONE, 15, 15, 16'hffff);
        send_cmd(sros_pkg::CMD_SERVE, 0, 0, 16'hffff);
        send_cmd(sros_pkg::CMD_SERVE, 0, 0, 1);
        send_cmd(sros_pkg::CMD_SERVE, 0, 1, 0);
        send_cmd(sros_pkg::CMD_SERVE, 0, 1, 0);
        send_cmd(sros_pkg::CMD_SERVE, 0, 3, 0);
        send_cmd(sros_pkg::CMD_SERVE, 0, 2, 0);
        send_cmd(sros_pkg::CMD_ARRIVE, 0, 0, 0);
        // run of advances before a serve, for a larger delay
        for (int i = 0; i < 4; i++)
            send_cmd(sros_pkg::CMD_ADVANCE, 0, 0, 0);
        send_cmd(sros_pkg::CMD_SERVE, 0, 0, 5);

        // random phases across limit settings
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_set_limit(limits[ph]);
            if (ph == 4)
                calm = 1'b1;
            for (int i = 0; i < RAND_ITEMS / 5; i++)
                random_cmd();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/sros_pkg.sv
hdl/sros_cell.sv
hdl/sros_queue.sv
hdl/switch_random_output_scheduler.sv
dv/switch_random_output_scheduler_chk.sv
dv/switch_random_output_scheduler_tb.sv
